// ===== rtl/heartbeat_liveness_supervisor_assert.svh =====
// Assertion macros for the heartbeat liveness supervisor.
`ifndef HEARTBEAT_LIVENESS_SUPERVISOR_ASSERT_SVH
`define HEARTBEAT_LIVENESS_SUPERVISOR_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted
`define HLS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("heartbeat supervisor check failed");
// Clocked check that also holds during reset
`define HLS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("heartbeat supervisor check failed");
`else
`define HLS_ASSERT(lbl, clk, rst_n, prop)
`define HLS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/hls_pkg.sv =====
// Types and constants shared by the heartbeat liveness supervisor.
package hls_pkg;

	localparam int GRACE_W    = 20;
	localparam int COUNT_W    = 4;
	localparam int OP_W       = 2;
	localparam int SRC_W      = 3;
	localparam int ALIVE_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 20;

	localparam logic [GRACE_W-1:0] GRACE_RESET = 20'd40000;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRACE_MS     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LIVELINESS = 2'd0,
		OP_RECOVERY   = 2'd1,
		OP_TICK       = 2'd2,
		OP_START      = 2'd3
	} op_t;

	typedef enum logic {
		W_IDLE = 1'b0,
		W_SCAN = 1'b1
	} walk_state_t;

	// Operation request handed to the flag store
	typedef struct packed {
		logic valid;
		op_t  op;
		logic alive_now;
	} op_req_t;

endpackage

// ===== rtl/hls_state.sv =====
// Per-source flag store, millisecond counter and report-mask decision.
module hls_state #(
	parameter int MAX_SOURCES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hls_pkg::op_req_t              req,
	input  logic [MAX_SOURCES-1:0]        sel,
	input  logic [MAX_SOURCES-1:0]        inuse,
	input  logic [hls_pkg::GRACE_W-1:0]   grace,
	output logic [MAX_SOURCES-1:0]        rep_mask
);
	import hls_pkg::*;

	logic [MAX_SOURCES-1:0] alive_q, ever_q, stale_q;
	logic [MAX_SOURCES-1:0] alive_d, ever_d, stale_d;
	logic [GRACE_W-1:0]     elapsed_q, elapsed_d, elapsed_inc;
	logic                   armed_q, armed_d;
	logic                   past_now, tick_past;
	logic [MAX_SOURCES-1:0] active, chk, rep;

	assign past_now    = (elapsed_q >= grace);
	assign elapsed_inc = elapsed_q + 1'b1;
	// after this tick's increment the count is at or past grace
	assign tick_past   = past_now || (elapsed_inc == grace);
	assign active      = sel & inuse;
	assign chk         = (~ever_q | ~alive_q) & inuse;

	// next flags and reports for the requested operation
	always_comb begin
		alive_d   = alive_q;
		ever_d    = ever_q;
		elapsed_d = elapsed_q;
		armed_d   = armed_q;
		rep       = '0;
		stale_d   = stale_q;
		unique case (req.op)
			OP_LIVELINESS: begin
				alive_d = (alive_q & ~active) | (req.alive_now ? active : '0);
				ever_d  = ever_q | (req.alive_now ? active : '0);
				if (!req.alive_now && past_now) begin
					rep = active & alive_q & ~stale_q;
				end
				stale_d = stale_q | rep;
			end
			OP_RECOVERY: begin
				rep     = ~alive_q & inuse;
				stale_d = rep;
			end
			OP_TICK: begin
				if (!past_now) begin
					elapsed_d = elapsed_inc;
				end
				if (armed_q && tick_past) begin
					armed_d = 1'b0;
					alive_d = alive_q & ~chk;
					rep     = chk & ~stale_q;
				end
				stale_d = stale_q | rep;
			end
			OP_START: begin
				alive_d   = '1;
				ever_d    = '0;
				stale_d   = '0;
				elapsed_d = '0;
				armed_d   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rep_mask = req.valid ? rep : '0;

	// state registers, reset as after a start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q   <= '1;
			ever_q    <= '0;
			stale_q   <= '0;
			elapsed_q <= '0;
			armed_q   <= 1'b1;
		end else if (req.valid) begin
			alive_q   <= alive_d;
			ever_q    <= ever_d;
			stale_q   <= stale_d;
			elapsed_q <= elapsed_d;
			armed_q   <= armed_d;
		end
	end

endmodule

// ===== rtl/hls_walk.sv =====
// Report sequencer: walks the report mask one source a cycle.
module hls_walk #(
	parameter int MAX_SOURCES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [MAX_SOURCES-1:0]      mask,
	output logic                        busy,
	output logic                        strobe,
	output logic [hls_pkg::SRC_W-1:0]   anomaly_source,
	output logic                        last
);
	import hls_pkg::*;

	localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	walk_state_t             state_q, state_d;
	logic [MAX_SOURCES-1:0]  mask_q, mask_d, bit_sel, remaining;
	logic [IDX_W-1:0]        cnt_q, cnt_d;
	logic [IDX_W+SRC_W-1:0]  cnt_ext;
	logic                    hit, emit;
	logic                    strobe_q;
	logic [SRC_W-1:0]        src_q;
	logic                    last_q;

	// one-hot of the current position
	always_comb begin
		for (int i = 0; i < MAX_SOURCES; i++) begin
			bit_sel[i] = (cnt_q == IDX_W'(i));
		end
	end

	assign hit       = |(mask_q & bit_sel);
	assign remaining = mask_q & ~bit_sel;
	assign cnt_ext   = {{SRC_W{1'b0}}, cnt_q};

	// sequencer next state
	always_comb begin
		state_d = state_q;
		mask_d  = mask_q;
		cnt_d   = cnt_q;
		emit    = 1'b0;
		unique case (state_q)
			W_IDLE: begin
				if (load) begin
					state_d = W_SCAN;
					mask_d  = mask;
					cnt_d   = '0;
				end
			end
			W_SCAN: begin
				emit   = hit;
				mask_d = remaining;
				cnt_d  = cnt_q + 1'b1;
				if (remaining == '0) begin
					state_d = W_IDLE;
				end
			end
			default: begin
				state_d = W_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= W_IDLE;
			mask_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mask_q   <= mask_d;
			strobe_q <= emit;
		end
	end

	// position and result beat payload
	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		if (emit) begin
			src_q  <= cnt_ext[SRC_W-1:0];
			last_q <= (remaining == '0);
		end
	end

	assign busy           = (state_q == W_SCAN);
	assign strobe         = strobe_q;
	assign anomaly_source = src_q;
	assign last           = last_q;

endmodule

// ===== rtl/heartbeat_liveness_supervisor.sv =====
// Top level of the heartbeat liveness supervisor.
//
// Usage:
//   Command channel: an operation (liveliness change, recovery, tick, start)
//   is taken at a rising edge with start high and busy low.
//   Result channel: each report is shown for one cycle with strobe high,
//   carrying anomaly_source and last (set on the final report of the
//   command). Reports come in ascending source order, at most one a cycle.
//   A reporting command loads its report mask into the sequencer, which
//   scans from source 0 and registers each report onto the ports. A command
//   that reports nothing leaves busy low and the next command may follow in
//   the next cycle; one that reports keeps busy high until the sequencer,
//   walking the sources one per cycle, has passed the highest reported source.
//   Configuration: cfg_we writes grace_ms (index 0) or source_count
//   (index 1) from cfg_data at once; write only while idle.
//   Reset: all sources alive, never-alive, not stale, elapsed count zero,
//   startup check armed; grace_ms 40000, source_count 2.
//   The receiver cannot stall: every strobe beat is taken as it appears.
module heartbeat_liveness_supervisor #(
	parameter int MAX_SOURCES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hls_pkg::OP_W-1:0]        operation,
	input  logic [hls_pkg::SRC_W-1:0]       source_index,
	input  logic [hls_pkg::ALIVE_W-1:0]     pub_count,
	output logic                            strobe,
	output logic [hls_pkg::SRC_W-1:0]       anomaly_source,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [hls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hls_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import hls_pkg::*;

	logic [GRACE_W-1:0]     grace_q;
	logic [COUNT_W-1:0]     count_q;
	logic [MAX_SOURCES-1:0] sel, inuse, rep_mask;
	op_req_t                req;
	logic                   accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_q <= GRACE_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRACE_MS) begin
				grace_q <= cfg_data[GRACE_W-1:0];
			end else if (cfg_index == REG_SOURCE_COUNT) begin
				count_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	// source decode; counts above the array clamp naturally
	always_comb begin
		for (int i = 0; i < MAX_SOURCES; i++) begin
			sel[i]   = (int'(source_index) == i);
			inuse[i] = (int'(count_q) > i);
		end
	end

	assign accept        = start && !busy;
	assign req.valid     = accept;
	assign req.op        = op_t'(operation);
	assign req.alive_now = |pub_count;

	hls_state #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.sel      (sel),
		.inuse    (inuse),
		.grace    (grace_q),
		.rep_mask (rep_mask)
	);

	hls_walk #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept && (|rep_mask)),
		.mask           (rep_mask),
		.busy           (busy),
		.strobe         (strobe),
		.anomaly_source (anomaly_source),
		.last           (last)
	);

	`include "heartbeat_liveness_supervisor_assert.svh"

	// a report that is not the last one comes while the walk is still running
	`HLS_ASSERT(a_more_while_busy, clk, arst_n, strobe && !last |-> busy)
	// the final report closes the burst
	`HLS_ASSERT(a_last_ends_burst, clk, arst_n, strobe && last |=> !strobe)
	// a walk only begins on an accepted command
	`HLS_ASSERT(a_busy_from_cmd, clk, arst_n, $rose(busy) |-> $past(start))

endmodule

// ===== tb/tb_heartbeat_liveness_supervisor.sv =====
// Self-checking testbench for the heartbeat liveness supervisor: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb_heartbeat_liveness_supervisor;
	import hls_pkg::*;

	localparam int MAX_SRC    = 8;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYC = MAX_SRC + 4;

	typedef struct packed {
		logic [SRC_W-1:0] src;
		logic             last_flag;
	} report_t;

	// Flag model of the supervisor plus the queue of reports still owed by the block
	class liveness_scoreboard;
		logic [GRACE_W-1:0] grace;
		logic [COUNT_W-1:0] src_in_use;
		logic [MAX_SRC-1:0] alive;
		logic [MAX_SRC-1:0] ever;
		logic [MAX_SRC-1:0] stale;
		logic [GRACE_W-1:0] elapsed;
		logic               armed;
		report_t            batch[$];
		report_t            expected_reports[$];
		int                 errors;
		int                 commands;
		int                 checked;

		function new();
			grace      = GRACE_RESET;
			src_in_use = COUNT_RESET;
			restart();
		endfunction

		function void restart();
			alive   = '1;
			ever    = '0;
			stale   = '0;
			elapsed = '0;
			armed   = 1'b1;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_GRACE_MS) begin
				grace = data[GRACE_W-1:0];
			end else if (idx == REG_SOURCE_COUNT) begin
				src_in_use = data[COUNT_W-1:0];
			end
		endfunction

		// A stale source stays quiet; reporting marks it stale
		function void flag_source(int unsigned i);
			report_t r;
			if (!stale[i]) begin
				stale[i]    = 1'b1;
				r.src       = SRC_W'(i);
				r.last_flag = 1'b0;
				batch.insert(batch.size(), r);
			end
		endfunction

		// Note an accepted command beat and queue the reports it owes
		function void note_command(op_t op, logic [SRC_W-1:0] idx, logic [ALIVE_W-1:0] cnt);
			int unsigned used;
			logic        was;
			used = (src_in_use > MAX_SRC) ? MAX_SRC : src_in_use;
			batch.delete();
			commands++;
			case (op)
			OP_LIVELINESS: begin
				if (idx < used) begin
					was        = alive[idx];
					alive[idx] = (cnt != '0);
					if (cnt != '0)
						ever[idx] = 1'b1;
					if (cnt == '0 && was && elapsed >= grace)
						flag_source(idx);
				end
			end
			OP_RECOVERY: begin
				stale = '0;
				for (int i = 0; i < used; i++)
					if (!alive[i])
						flag_source(i);
			end
			OP_TICK: begin
				if (elapsed < grace)
					elapsed++;
				if (armed && elapsed >= grace) begin
					armed = 1'b0;
					for (int i = 0; i < used; i++) begin
						if (!ever[i] || !alive[i]) begin
							alive[i] = 1'b0;
							flag_source(i);
						end
					end
				end
			end
			default: begin
				restart();
			end
			endcase
			if (batch.size() != 0)
				batch[$].last_flag = 1'b1;
			foreach (batch[i])
				expected_reports.insert(expected_reports.size(), batch[i]);
		endfunction

		// Compare one report beat with the oldest one owed
		function void check_report(logic [SRC_W-1:0] src, logic lst);
			report_t want;
			if (expected_reports.size() == 0) begin
				$error("unexpected report: anomaly_source %0d last %0d", src, lst);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				checked++;
				if (src !== want.src) begin
					$error("anomaly_source: expected %0d, got %0d", want.src, src);
					errors++;
				end
				if (lst !== want.last_flag) begin
					$error("last: expected %0d, got %0d", want.last_flag, lst);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic                  busy;
	logic [OP_W-1:0]       operation    = '0;
	logic [SRC_W-1:0]      source_index = '0;
	logic [ALIVE_W-1:0]    pub_count    = '0;
	logic                  strobe;
	logic [SRC_W-1:0]      anomaly_source;
	logic                  last;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	liveness_scoreboard sb = new();
	int  idle_cycles = 0;
	int  burst_left  = 0;
	int  reg_writes  = 0;
	bit  gaps_on     = 1'b1;

	heartbeat_liveness_supervisor #(.MAX_SOURCES(MAX_SRC)) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.source_index   (source_index),
		.pub_count      (pub_count),
		.strobe         (strobe),
		.anomaly_source (anomaly_source),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	// Every strobe beat is taken as it appears
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1)
			sb.check_report(anomaly_source, last);
	end

	// Watchdog: too long with no beat on any port ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || strobe === 1'b1 || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_heartbeat_liveness_supervisor failed");
				$finish;
			end
		end
	end

	// Present one command and hold it until taken; start stays high within a burst
	task automatic issue_command(op_t op, logic [SRC_W-1:0] idx, logic [ALIVE_W-1:0] cnt);
		start        <= 1'b1;
		operation    <= op;
		source_index <= idx;
		pub_count    <= cnt;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_command(op, idx, cnt);
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(0, 11);
			end
		end
	endtask

	// Drain all owed reports and let a silent walk finish
	task automatic settle();
		start <= 1'b0;
		while (sb.expected_reports.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
		reg_writes++;
		@(posedge clk);
	endtask

	// Mostly liveliness and ticks, some recoveries, the odd restart
	task automatic random_command();
		int unsigned pick;
		logic [ALIVE_W-1:0] cnt;
		pick = $urandom_range(0, 99);
		cnt  = ($urandom_range(0, 2) == 0) ? '0 : ALIVE_W'($urandom);
		if (pick < 50)
			issue_command(OP_LIVELINESS, SRC_W'($urandom_range(0, 7)), cnt);
		else if (pick < 75)
			issue_command(OP_TICK, SRC_W'($urandom), cnt);
		else if (pick < 96)
			issue_command(OP_RECOVERY, SRC_W'($urandom), cnt);
		else
			issue_command(OP_START, SRC_W'($urandom), cnt);
	endtask

	initial begin
		logic [GRACE_W-1:0] phase_grace[8];
		logic [COUNT_W-1:0] phase_count[8];

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Grace of three ticks, four sources
		settle();
		write_reg(REG_GRACE_MS, 20'd3);
		write_reg(REG_SOURCE_COUNT, 20'd4);
		issue_command(OP_LIVELINESS, 3'd0, 16'hFFFF);
		issue_command(OP_LIVELINESS, 3'd1, 16'h0001);
		issue_command(OP_LIVELINESS, 3'd5, 16'h0000);  // not in use
		issue_command(OP_LIVELINESS, 3'd1, 16'h0000);  // loss inside grace
		repeat (3) issue_command(OP_TICK, 3'd0, 16'h0000);  // startup check
		issue_command(OP_LIVELINESS, 3'd0, 16'h0000);
		issue_command(OP_LIVELINESS, 3'd0, 16'h0000);  // already dead
		issue_command(OP_RECOVERY, 3'd7, 16'hFFFF);
		issue_command(OP_RECOVERY, 3'd0, 16'h0000);
		issue_command(OP_TICK, 3'd0, 16'h0000);        // check already done
		issue_command(OP_START, 3'd0, 16'h0000);

		// Zero grace, count above the maximum
		settle();
		write_reg(REG_GRACE_MS, 20'd0);
		write_reg(REG_SOURCE_COUNT, 20'hFFFFF);
		issue_command(OP_TICK, 3'd0, 16'h0000);
		issue_command(OP_LIVELINESS, 3'd7, 16'h8000);
		issue_command(OP_LIVELINESS, 3'd7, 16'h0000);  // stale, stays quiet
		issue_command(OP_RECOVERY, 3'd0, 16'h0000);

		// No source in use
		settle();
		write_reg(REG_SOURCE_COUNT, 20'd0);
		issue_command(OP_START, 3'd0, 16'h0000);
		issue_command(OP_LIVELINESS, 3'd0, 16'hFFFF);
		issue_command(OP_TICK, 3'd0, 16'h0000);
		issue_command(OP_RECOVERY, 3'd0, 16'h0000);

		// Longest grace, then lowered below the elapsed count
		settle();
		write_reg(REG_GRACE_MS, 20'hFFFFF);
		write_reg(REG_SOURCE_COUNT, 20'd8);
		issue_command(OP_START, 3'd0, 16'h0000);
		issue_command(OP_LIVELINESS, 3'd2, 16'h0001);
		repeat (5) issue_command(OP_TICK, 3'd0, 16'h0000);
		settle();
		write_reg(REG_GRACE_MS, 20'd2);
		issue_command(OP_TICK, 3'd0, 16'h0000);
		issue_command(OP_LIVELINESS, 3'd2, 16'h0000);

		// Random phases, each under its own register setting
		phase_grace = '{20'd2, 20'd0, 20'd6, 20'hFFFFF, 20'd1, 20'd4,
			GRACE_W'($urandom_range(0, 10)), GRACE_W'($urandom_range(0, 10))};
		phase_count = '{4'd2, 4'd8, 4'd15, 4'd4, 4'd0, 4'd1,
			COUNT_W'($urandom_range(0, 15)), COUNT_W'($urandom_range(1, 8))};
		for (int p = 0; p < 8; p++) begin
			settle();
			write_reg(REG_GRACE_MS, phase_grace[p]);
			write_reg(REG_SOURCE_COUNT, {16'($urandom), phase_count[p]});
			gaps_on = (p != 2);
			issue_command(OP_START, SRC_W'($urandom), ALIVE_W'($urandom));
			repeat (36) random_command();
		end

		// Drain, then watch for stray reports
		settle();
		if (sb.expected_reports.size() != 0) begin
			$error("%0d reports never arrived", sb.expected_reports.size());
			sb.errors++;
		end
		$display("Covered %0d commands and %0d register writes; %0d report beats checked.",
			sb.commands, reg_writes, sb.checked);
		if (sb.errors == 0)
			$display("tb_heartbeat_liveness_supervisor passed");
		else
			$display("tb_heartbeat_liveness_supervisor failed");
		$finish;
	end

endmodule
